// File: rtl/fixed_point_q24_8_alu_defines.svh
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_defines
// Assertion macros used by the ALU RTL file fpa_back.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_Q24_8_ALU_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define FPA_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define FPA_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Types and constants shared by the fixed-point ALU modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

    localparam int FIELD_W          = 32;
    localparam int FRAC_BITS_DEF    = 8;
    localparam int DATA_WIDTH_DEF   = 32;
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_EQ       = 4'd6,
        OP_NE       = 4'd7,
        OP_GE       = 4'd8,
        OP_LE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } op_e;

    typedef struct packed {
        logic [3:0]                 opcode;
        logic signed [FIELD_W-1:0]  operand_a;
        logic signed [FIELD_W-1:0]  operand_b;
    } req_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  result_value;
        logic                       compare_true;
        logic                       divide_by_zero;
    } rsp_t;

    // classified item: operands already sign-extended from the data width
    typedef struct packed {
        op_e                        op;
        logic signed [FIELD_W-1:0]  a;
        logic signed [FIELD_W-1:0]  b;
        logic                       dz;
    } cls_t;

endpackage

`default_nettype wire

// File: rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Accepts request items, narrows operands to the data width and flags
// divide by zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpa_front
    import fpa_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   req_valid,
    output logic        req_stall,
    input  wire req_t   req,
    output logic        cls_valid,
    input  wire logic   cls_full,
    output cls_t        cls
);

    localparam int SH = FIELD_W - DATA_WIDTH;

    logic valid_reg;
    logic valid_next;
    cls_t item_reg;
    cls_t item_next;
    logic signed [FIELD_W-1:0] a_sh;
    logic signed [FIELD_W-1:0] b_sh;
    logic take;

    assign req_stall = valid_reg && cls_full;
    assign take      = req_valid && !req_stall;

    always_comb
    begin
        a_sh           = req.operand_a <<< SH;
        b_sh           = req.operand_b <<< SH;
        item_next.op   = op_e'(req.opcode);
        item_next.a    = a_sh >>> SH;
        item_next.b    = b_sh >>> SH;
        item_next.dz   = (op_e'(req.opcode) == OP_DIV) && (b_sh == '0);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (!cls_full)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign cls_valid = valid_reg;
    assign cls       = item_reg;

endmodule

`default_nettype wire

// File: rtl/fpa_queue.sv
// ----------------------------------------------------------------------------
// fpa_queue
// Short FIFO of classified items between front end and execution pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpa_queue
    import fpa_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push_valid,
    output logic        full,
    input  wire cls_t   push_item,
    output logic        pop_valid,
    input  wire logic   pop,
    output cls_t        pop_item
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cls_t           mem [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Execution pipeline: operand prep and multiply, one restoring divide step
// per stage, then result select into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_point_q24_8_alu_defines.svh"

module fpa_back
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   item_valid,
    output logic        item_pop,
    input  wire cls_t   item,
    output logic        rsp_valid,
    input  wire logic   rsp_stall,
    output rsp_t        rsp
);

    localparam int DW = DATA_WIDTH;
    localparam int NQ = DATA_WIDTH + FRAC_BITS;
    localparam int NS = NQ + 1;
    localparam int SH = FIELD_W - DATA_WIDTH;

    logic                   v_reg   [NS];
    op_e                    op_reg  [NS];
    logic signed [DW-1:0]   a_reg   [NS];
    logic signed [DW-1:0]   b_reg   [NS];
    logic signed [2*DW-1:0] p_reg   [NS];
    logic                   neg_reg [NS];
    logic                   dz_reg  [NS];
    logic [DW-1:0]          d_reg   [NS];
    logic [DW:0]            r_reg   [NS];
    logic [NQ-1:0]          w_reg   [NS];

    logic [DW:0]            r_next  [NS];
    logic [NQ-1:0]          w_next  [NS];

    logic                   out_valid_reg;
    rsp_t                   out_reg;
    logic                   adv;

    logic signed [DW-1:0]   ia;
    logic signed [DW-1:0]   ib;
    logic [DW-1:0]          mag_a;
    logic [DW-1:0]          mag_b;

    logic signed [DW-1:0]   fa;
    logic signed [DW-1:0]   fb;
    logic signed [2*DW-1:0] p_sh;
    logic [DW-1:0]          q_w;
    logic signed [DW-1:0]   res_w;
    logic signed [FIELD_W-1:0] res_sh;
    logic                   cmp;
    logic                   lt_ab;
    logic                   lt_ba;

    // whole pipeline moves together; the output register is the last stage
    assign adv      = !out_valid_reg || !rsp_stall;
    assign item_pop = adv;

    assign ia    = item.a[DW-1:0];
    assign ib    = item.b[DW-1:0];
    assign mag_a = ia[DW-1] ? DW'(-ia) : DW'(ia);
    assign mag_b = ib[DW-1] ? DW'(-ib) : DW'(ib);

    // one restoring step per stage; remainder stays below a nonzero divisor
    always_comb
    begin
        r_next[0] = '0;
        w_next[0] = '0;
        for (int k = 1; k < NS; k++)
        begin
            logic [DW:0] rs;
            logic        ge;
            rs        = {r_reg[k-1][DW-1:0], w_reg[k-1][NQ-1]};
            ge        = (rs >= {1'b0, d_reg[k-1]});
            r_next[k] = ge ? rs - {1'b0, d_reg[k-1]} : rs;
            w_next[k] = {w_reg[k-1][NQ-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= item_valid;
            for (int k = 1; k < NS; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg[0]  <= item.op;
            a_reg[0]   <= ia;
            b_reg[0]   <= ib;
            p_reg[0]   <= ia * ib;
            neg_reg[0] <= ia[DW-1] ^ ib[DW-1];
            dz_reg[0]  <= item.dz;
            d_reg[0]   <= mag_b;
            r_reg[0]   <= '0;
            w_reg[0]   <= {mag_a, {FRAC_BITS{1'b0}}};
            for (int k = 1; k < NS; k++)
            begin
                op_reg[k]  <= op_reg[k-1];
                a_reg[k]   <= a_reg[k-1];
                b_reg[k]   <= b_reg[k-1];
                p_reg[k]   <= p_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                dz_reg[k]  <= dz_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
                r_reg[k]   <= r_next[k];
                w_reg[k]   <= w_next[k];
            end
        end
    end

    // result select from the last stage
    always_comb
    begin
        fa    = a_reg[NS-1];
        fb    = b_reg[NS-1];
        lt_ab = fa < fb;
        lt_ba = fb < fa;
        p_sh  = p_reg[NS-1] >>> FRAC_BITS;
        q_w   = w_reg[NS-1][DW-1:0];
        res_w = '0;
        cmp   = 1'b0;
        unique case (op_reg[NS-1])
            OP_ADD:      res_w = fa + fb;
            OP_SUB:      res_w = fa - fb;
            OP_MUL:      res_w = p_sh[DW-1:0];
            OP_DIV:      res_w = dz_reg[NS-1] ? '0 : (neg_reg[NS-1] ? -q_w : q_w);
            OP_GT:       cmp   = lt_ba;
            OP_LT:       cmp   = lt_ab;
            OP_EQ:       cmp   = (fa == fb);
            OP_NE:       cmp   = (fa != fb);
            OP_GE:       cmp   = !lt_ab;
            OP_LE:       cmp   = !lt_ba;
            OP_MIN:      res_w = lt_ab ? fa : fb;
            OP_MAX:      res_w = lt_ba ? fa : fb;
            OP_INC:      res_w = fa + 1'b1;
            OP_DEC:      res_w = fa - 1'b1;
            OP_FROM_INT: res_w = fa <<< FRAC_BITS;
            OP_TO_INT:   res_w = fa >>> FRAC_BITS;
            default:     res_w = '0;
        endcase
        res_sh = FIELD_W'(res_w) <<< SH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.result_value   <= res_sh >>> SH;
            out_reg.compare_true   <= cmp;
            out_reg.divide_by_zero <= dz_reg[NS-1];
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `FPA_ASSERT_NOW(a_dz_zero,
        out_valid_reg && out_reg.divide_by_zero,
        (out_reg.result_value == '0) && !out_reg.compare_true,
        "divide by zero item carries a nonzero result")
    `FPA_ASSERT_NOW(a_cmp_zero,
        out_valid_reg && out_reg.compare_true,
        out_reg.result_value == '0,
        "comparison item carries a nonzero result")
    `FPA_ASSERT_NOW(a_dz_div,
        v_reg[0] && dz_reg[0],
        op_reg[0] == OP_DIV,
        "divide by zero flag on a non-divide item")
    `FPA_ASSERT_NEXT(a_stall_hold,
        out_valid_reg && rsp_stall,
        out_valid_reg && $stable(out_reg),
        "stalled result item changed")

endmodule

`default_nettype wire

// File: rtl/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Signed fixed-point ALU: add, sub, mul, div, compares, min/max, inc/dec and
// integer conversions on raw Q24.8 operands.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one item: opcode and two
//   raw operands. rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one
//   item per request, in request order: result, compare flag, divide-by-zero.
//   An item passes through the front register, the queue, the operand/multiply
//   stage, one stage per quotient bit of the restoring divider and the output
//   register. Every opcode runs through the same pipeline, so throughput is one
//   item per cycle while rsp is not stalled.
//   A stall on rsp with rsp_valid high freezes the execution pipeline; the
//   two-entry queue and the front register keep taking items until they fill, then req_stall rises.
//   Reset clears all valid state; no items are in flight after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_q24_8_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   req_valid,
    output logic        req_stall,
    input  wire req_t   req,
    output logic        rsp_valid,
    input  wire logic   rsp_stall,
    output rsp_t        rsp
);

    logic cls_valid;
    logic cls_full;
    cls_t cls;
    logic q_valid;
    logic q_pop;
    cls_t q_item;

    fpa_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .cls_valid  (cls_valid),
        .cls_full   (cls_full),
        .cls        (cls)
    );

    fpa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cls_valid),
        .full       (cls_full),
        .push_item  (cls),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    fpa_back #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_pop   (q_pop),
        .item       (q_item),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire
